/* rtl/core/ssrch_pkg.sv */
package ssrch_pkg;

    localparam int MAX_PATTERN_DEFAULT = 16;
    localparam int PAT_BYTES           = 16;
    localparam int PAT_IDX_W           = 4;
    localparam int LEN_W               = 5;
    localparam int OFFSET_W            = 32;
    localparam int CFG_DATA_W          = 64;
    localparam int CFG_INDEX_W         = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CASE_FOLD      = 2'd3;

    localparam logic [7:0] TERMINATOR   = 8'h00;
    localparam logic [7:0] UPPER_FIRST  = 8'h41;
    localparam logic [7:0] UPPER_LAST   = 8'h5A;
    localparam logic [7:0] CASE_DELTA   = 8'h20;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             fold;
    } pat_ctl_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && (b >= UPPER_FIRST) && (b <= UPPER_LAST))
        begin
            r = b + CASE_DELTA;
        end
        return r;
    endfunction

endpackage

/* rtl/core/ssrch_cell.sv */
module ssrch_cell
    import ssrch_pkg::*;
(
    input  logic       clk,
    input  logic       shift,
    input  logic [7:0] byte_in,
    output logic [7:0] byte_out,
    input  logic       fold,
    input  logic [7:0] pat_byte,
    input  logic       care,
    output logic       hit
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
    assign hit      = !care || (fold_byte(byte_reg, fold) == pat_byte);

endmodule

/* rtl/core/ssrch_pat_align.sv */
module ssrch_pat_align
    import ssrch_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [CFG_DATA_W-1:0]        pattern_low,
    input  logic [CFG_DATA_W-1:0]        pattern_high,
    input  logic [LEN_W-1:0]             pattern_length,
    input  logic                         case_fold,
    output pat_ctl_t                     ctl,
    output logic [MAX_PATTERN-1:0][7:0]  pat_bytes,
    output logic [MAX_PATTERN-1:0]       care
);

    logic [PAT_BYTES-1:0][7:0]     raw;
    logic [LEN_W-1:0]              lim;
    logic [LEN_W-1:0]              eff_len;
    logic [MAX_PATTERN-1:0][7:0]   pat_bytes_next;
    logic [MAX_PATTERN-1:0]        care_next;
    pat_ctl_t                      ctl_next;
    pat_ctl_t                      ctl_reg;
    logic [MAX_PATTERN-1:0][7:0]   pat_bytes_reg;
    logic [MAX_PATTERN-1:0]        care_reg;

    assign raw = {pattern_high, pattern_low};

    always_comb
    begin
        lim = (pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pattern_length;
        eff_len = lim;
        for (int i = PAT_BYTES - 1; i >= 0; i--)
        begin
            if ((LEN_W'(i) < lim) && (raw[i] == TERMINATOR))
            begin
                eff_len = LEN_W'(i);
            end
        end
    end

    // align so that lane j faces the byte received j transfers ago
    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_lane
        logic [LEN_W-1:0] idx;
        assign idx               = eff_len - LEN_W'(j + 1);
        assign pat_bytes_next[j] = fold_byte(raw[idx[PAT_IDX_W-1:0]], case_fold);
        assign care_next[j]      = LEN_W'(j) < eff_len;
    end

    assign ctl_next.len  = eff_len;
    assign ctl_next.fold = case_fold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            care_reg <= '0;
        end
        else
        begin
            ctl_reg  <= ctl_next;
            care_reg <= care_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_bytes_reg <= pat_bytes_next;
    end

    assign ctl       = ctl_reg;
    assign pat_bytes = pat_bytes_reg;
    assign care      = care_reg;

endmodule

/* rtl/core/substring_search_top.sv */
// Path: an accepted byte is registered in the s1 stage, then its result is written to the
// result buffer and offered on the output from there.
// Throughput: one text byte per cycle, with a combinational compare across the cell row;
// in_ready drops only while the two-entry result buffer could not take another result.
// Reset: rst_n (asynchronous, active low) clears the registers, the counters and the buffer;
// the window cells are not cleared and are masked by the fill count.
module substring_search_top
    import ssrch_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              text_byte,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    found,
    output logic [OFFSET_W-1:0]     match_offset
);

    logic [CFG_DATA_W-1:0]         pattern_low_reg;
    logic [CFG_DATA_W-1:0]         pattern_high_reg;
    logic [LEN_W-1:0]              pattern_length_reg;
    logic                          case_fold_reg;

    pat_ctl_t                      ctl;
    logic [MAX_PATTERN-1:0][7:0]   pat_bytes;
    logic [MAX_PATTERN-1:0]        care;
    logic [MAX_PATTERN-1:0][7:0]   win;
    logic [MAX_PATTERN-1:0]        hit;

    logic                          accept;
    logic                          term;
    logic                          shift;

    logic [LEN_W-1:0]              fill_reg;
    logic [OFFSET_W-1:0]           offset_reg;
    logic                          reported_reg;
    logic                          reported_next;
    logic                          s1_valid_reg;
    logic                          s1_term_reg;
    logic                          s1_first_reg;

    logic                          res;
    logic                          res_found;
    logic [OFFSET_W-1:0]           res_offset;

    logic [1:0]                    count_reg;
    logic [1:0]                    count_next;
    logic                          wr_ptr_reg;
    logic                          rd_ptr_reg;
    logic [1:0]                    ent_found_reg;
    logic [1:0][OFFSET_W-1:0]      ent_offset_reg;
    logic                          push;
    logic                          pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
            case_fold_reg      <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                REG_CASE_FOLD:      case_fold_reg      <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    ssrch_pat_align #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_pat_align (
        .clk            (clk),
        .rst_n          (rst_n),
        .pattern_low    (pattern_low_reg),
        .pattern_high   (pattern_high_reg),
        .pattern_length (pattern_length_reg),
        .case_fold      (case_fold_reg),
        .ctl            (ctl),
        .pat_bytes      (pat_bytes),
        .care           (care)
    );

    assign accept = in_valid && in_ready;
    assign term   = (text_byte == TERMINATOR);
    assign shift  = accept && !term;

    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_cell
        logic [7:0] byte_in;
        if (j == 0)
        begin : g_head
            assign byte_in = text_byte;
        end
        else
        begin : g_link
            assign byte_in = win[j-1];
        end
        ssrch_cell u_cell (
            .clk      (clk),
            .shift    (shift),
            .byte_in  (byte_in),
            .byte_out (win[j]),
            .fold     (ctl.fold),
            .pat_byte (pat_bytes[j]),
            .care     (care[j]),
            .hit      (hit[j])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            offset_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s1_term_reg  <= 1'b0;
            s1_first_reg <= 1'b0;
            reported_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                s1_term_reg  <= term;
                s1_first_reg <= (offset_reg == '0);
                if (term)
                begin
                    fill_reg   <= '0;
                    offset_reg <= '0;
                end
                else
                begin
                    if (fill_reg < LEN_W'(MAX_PATTERN))
                    begin
                        fill_reg <= fill_reg + LEN_W'(1);
                    end
                    if (offset_reg != '1)
                    begin
                        offset_reg <= offset_reg + OFFSET_W'(1);
                    end
                end
            end
            reported_reg <= reported_next;
        end
    end

    always_comb
    begin
        res           = 1'b0;
        res_found     = 1'b0;
        res_offset    = '0;
        reported_next = reported_reg;
        if (s1_valid_reg)
        begin
            if ((ctl.len == '0) && !reported_reg && s1_first_reg)
            begin
                res           = 1'b1;
                res_found     = 1'b1;
                reported_next = !s1_term_reg;
            end
            else if (s1_term_reg)
            begin
                res           = !reported_reg;
                reported_next = 1'b0;
            end
            else if (!reported_reg && (ctl.len != '0) && (fill_reg >= ctl.len) && (&hit))
            begin
                res           = 1'b1;
                res_found     = 1'b1;
                res_offset    = offset_reg - OFFSET_W'(ctl.len);
                reported_next = 1'b1;
            end
        end
    end

    assign push     = res;
    assign pop      = out_valid && out_ready;
    assign in_ready = (count_next != 2'd2);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_found_reg[wr_ptr_reg]  <= res_found;
            ent_offset_reg[wr_ptr_reg] <= res_offset;
        end
    end

    assign out_valid    = (count_reg != 2'd0);
    assign found        = ent_found_reg[rd_ptr_reg];
    assign match_offset = ent_offset_reg[rd_ptr_reg];

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2))
        else $error("result pushed into a full buffer");

    a_not_found_on_term: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !res_found) |-> s1_term_reg)
        else $error("not-found result without a terminator");

    a_found_on_term_first: assert property (@(posedge clk) disable iff (!rst_n)
        (push && res_found && s1_term_reg) |-> (s1_first_reg && (ctl.len == '0)))
        else $error("found on terminator outside the empty-pattern case");

    a_term_clears_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_term_reg) |=> !reported_reg)
        else $error("reported flag survives a terminator");

endmodule
